// ===== hw/rtl/kpn_pkg.sv =====
package kpn_pkg;

  // Default width of the tested value and the largest exponent tried on an odd part.
  localparam int unsigned VALUE_WIDTH      = 64;
  localparam int unsigned MAX_ODD_EXPONENT = 40;

  // Sequencer states of the test.
  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_STRIP,
    S_ODD,
    S_PP_E,
    S_PP_BIT,
    S_PP_TEST,
    S_PP_END,
    S_POW_LOOP,
    S_POW_WAIT,
    S_T_POW,
    S_T_SQ,
    S_T_SQ_WAIT,
    S_T_DIV1,
    S_T_DIV1_WAIT,
    S_T_DIV2,
    S_T_DIV2_WAIT,
    S_T_DIV3,
    S_T_DIV3_WAIT,
    S_DONE
  } kpn_state_e;

endpackage

// ===== hw/rtl/kpn_mul.sv =====
// Shift-add multiplier: one bit of operand b per cycle, finishing once b runs out of ones.
module kpn_mul #(
  parameter int unsigned W = kpn_pkg::VALUE_WIDTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] p_o
);

  logic           busy_q, busy_d;
  logic [2*W-1:0] a_q, a_d;
  logic [W-1:0]   b_q, b_d;
  logic [2*W-1:0] p_q, p_d;

  // One partial product per cycle.
  always_comb begin
    busy_d = busy_q;
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      a_d    = {{W{1'b0}}, a_i};
      b_d    = b_i;
      p_d    = '0;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (b_q[0]) begin
          p_d = p_q + a_q;
        end
        a_d = a_q << 1;
        b_d = b_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/kpn_div.sv =====
// Restoring divider: one quotient bit per cycle.
module kpn_div #(
  parameter int unsigned W = kpn_pkg::VALUE_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(W + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    num_q, num_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    den_q, den_d;
  logic [W:0]      trial;

  // Shift in the next numerator bit and subtract where the divisor fits.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_o = 1'b0;
    trial  = {rem_q, num_q[W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (cnt_q == CntW'(W)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
        if (trial >= {1'b0, den_q}) begin
          rem_d = W'(trial - {1'b0, den_q});
          num_d = {num_q[W-2:0], 1'b1};
        end else begin
          rem_d = trial[W-1:0];
          num_d = {num_q[W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/k_powerful_number_test.sv =====
// k-powerful number test.
// The input channel carries a value n and an exponent k; the output channel returns one flag
// per beat, set when every prime dividing n divides it at least k times.
// Both channels use valid and stall; a beat moves when valid is high and stall is low.
// Only the low VALUE_WIDTH bits of the value are used.
// Run time: trivial cases (zero, one, k below two, failing power of two) finish straight from
// the check, and stripping twos shifts out one trailing zero at a time. Odd parts run a
// perfect-power search and then trial division by d = 3, 5, 7, ...; each divisor costs about
// k multiplications, a squaring and one or more divisions. Items with large prime factors
// take longest. The run time is set by the single shift-add multiplier and the single
// restoring divider, both shared by the sequencer.
// Input stall is high from acceptance until the result is loaded into the output register;
// the next item is accepted while a result still waits there.
// While the receiver stalls, the output beat holds and a finished result waits its turn.
// Reset returns the sequencer to idle and empties the output register.
module k_powerful_number_test #(
  parameter int unsigned VALUE_WIDTH      = kpn_pkg::VALUE_WIDTH,
  parameter int unsigned MAX_ODD_EXPONENT = kpn_pkg::MAX_ODD_EXPONENT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_i,
  input  logic [5:0]  exponent_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_powerful_flag_o
);

  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned HalfW = W / 2;
  localparam int unsigned BitW  = $clog2(HalfW + 1);
  localparam int unsigned BeW   = BitW + 7;
  localparam int unsigned DivW  = W / 4 + 2;

  kpn_pkg::kpn_state_e state_q, state_d;

  logic [W-1:0]    n_q, n_d;
  logic [5:0]      k_q, k_d;
  logic [6:0]      e_q, e_d;
  logic [BitW-1:0] b_q, b_d;
  logic [W-1:0]    root_q, root_d;
  logic            eqf_q, eqf_d;
  logic [W-1:0]    base_q, base_d;
  logic [W-1:0]    acc_q, acc_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            fit_q, fit_d;
  logic            pow_ctx_q, pow_ctx_d;
  logic            pp_ctx_q, pp_ctx_d;
  logic [DivW-1:0] d_q, d_d;
  logic [W-1:0]    pk_q, pk_d;
  logic            flag_q, flag_d;
  logic            out_valid_q, out_valid_d;
  logic            out_flag_q, out_flag_d;

  logic           mul_start, mul_done;
  logic [W-1:0]   mul_a, mul_b;
  logic [2*W-1:0] mul_p;
  logic           mul_over;
  logic           div_start, div_done;
  logic [W-1:0]   div_den, div_quot, div_rem;

  logic [W-1:0]   low_mask;
  logic [BeW-1:0] be;
  logic           load_out;

  kpn_mul #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  kpn_div #(.W(W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (n_q),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // Helpers: the low k bits, the root bit weight against the width, and a product above n.
  assign low_mask = ~({W{1'b1}} << k_q);
  assign be       = BeW'(b_q) * BeW'(e_q);
  assign mul_over = (mul_p[2*W-1:W] != '0) || (mul_p[W-1:0] > n_q);

  // Next state and datapath.
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    k_d       = k_q;
    e_d       = e_q;
    b_d       = b_q;
    root_d    = root_q;
    eqf_d     = eqf_q;
    base_d    = base_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    fit_d     = fit_q;
    pow_ctx_d = pow_ctx_q;
    pp_ctx_d  = pp_ctx_q;
    d_d       = d_q;
    pk_d      = pk_q;
    flag_d    = flag_q;
    unique case (state_q)
      kpn_pkg::S_IDLE: begin
        if (in_valid_i) begin
          n_d     = value_i[W-1:0];
          k_d     = exponent_i;
          state_d = kpn_pkg::S_CHECK;
        end
      end
      kpn_pkg::S_CHECK: begin
        if (n_q <= W'(1)) begin
          flag_d  = (n_q == W'(1));
          state_d = kpn_pkg::S_DONE;
        end else if (k_q <= 6'd1) begin
          flag_d  = 1'b1;
          state_d = kpn_pkg::S_DONE;
        end else if (!n_q[0]) begin
          if ((n_q & low_mask) != '0) begin
            flag_d  = 1'b0;
            state_d = kpn_pkg::S_DONE;
          end else begin
            state_d = kpn_pkg::S_STRIP;
          end
        end else begin
          state_d = kpn_pkg::S_ODD;
        end
      end
      kpn_pkg::S_STRIP: begin
        if (n_q[0]) begin
          if (n_q == W'(1)) begin
            flag_d  = 1'b1;
            state_d = kpn_pkg::S_DONE;
          end else begin
            state_d = kpn_pkg::S_ODD;
          end
        end else begin
          n_d = n_q >> 1;
        end
      end
      kpn_pkg::S_ODD: begin
        if (7'(k_q) > 7'(MAX_ODD_EXPONENT)) begin
          flag_d  = 1'b0;
          state_d = kpn_pkg::S_DONE;
        end else begin
          pp_ctx_d = 1'b0;
          e_d      = 7'(k_q);
          state_d  = kpn_pkg::S_PP_E;
        end
      end
      kpn_pkg::S_PP_E: begin
        if (e_q == 7'd64) begin
          d_d     = pp_ctx_q ? d_q + DivW'(2) : DivW'(3);
          state_d = kpn_pkg::S_T_POW;
        end else begin
          b_d     = BitW'(HalfW);
          root_d  = '0;
          eqf_d   = 1'b0;
          state_d = kpn_pkg::S_PP_BIT;
        end
      end
      kpn_pkg::S_PP_BIT: begin
        if (be >= BeW'(W)) begin
          b_d = b_q - 1'b1;
        end else begin
          base_d    = root_q | (W'(1) << b_q);
          acc_d     = W'(1);
          cnt_d     = e_q[5:0];
          pow_ctx_d = 1'b0;
          state_d   = kpn_pkg::S_POW_LOOP;
        end
      end
      kpn_pkg::S_PP_TEST: begin
        if (fit_q) begin
          root_d = base_q;
          eqf_d  = (acc_q == n_q);
        end
        if (b_q == '0) begin
          state_d = kpn_pkg::S_PP_END;
        end else begin
          b_d     = b_q - 1'b1;
          state_d = kpn_pkg::S_PP_BIT;
        end
      end
      kpn_pkg::S_PP_END: begin
        if (root_q < W'(2)) begin
          d_d     = pp_ctx_q ? d_q + DivW'(2) : DivW'(3);
          state_d = kpn_pkg::S_T_POW;
        end else if (eqf_q) begin
          flag_d  = 1'b1;
          state_d = kpn_pkg::S_DONE;
        end else begin
          e_d     = e_q + 1'b1;
          state_d = kpn_pkg::S_PP_E;
        end
      end
      kpn_pkg::S_POW_LOOP: begin
        if (cnt_q == '0) begin
          fit_d = 1'b1;
          if (pow_ctx_q) begin
            pk_d    = acc_q;
            state_d = kpn_pkg::S_T_SQ;
          end else begin
            state_d = kpn_pkg::S_PP_TEST;
          end
        end else begin
          state_d = kpn_pkg::S_POW_WAIT;
        end
      end
      kpn_pkg::S_POW_WAIT: begin
        if (mul_done) begin
          if (mul_over) begin
            fit_d = 1'b0;
            if (pow_ctx_q) begin
              pk_d    = '1;
              flag_d  = 1'b0;
              state_d = kpn_pkg::S_DONE;
            end else begin
              state_d = kpn_pkg::S_PP_TEST;
            end
          end else begin
            acc_d   = mul_p[W-1:0];
            cnt_d   = cnt_q - 1'b1;
            state_d = kpn_pkg::S_POW_LOOP;
          end
        end
      end
      kpn_pkg::S_T_POW: begin
        base_d    = W'(d_q);
        acc_d     = W'(1);
        cnt_d     = k_q;
        pow_ctx_d = 1'b1;
        state_d   = kpn_pkg::S_POW_LOOP;
      end
      kpn_pkg::S_T_SQ: begin
        state_d = kpn_pkg::S_T_SQ_WAIT;
      end
      kpn_pkg::S_T_SQ_WAIT: begin
        if (mul_done) begin
          if (mul_over) begin
            flag_d  = 1'b0;
            state_d = kpn_pkg::S_DONE;
          end else begin
            state_d = kpn_pkg::S_T_DIV1;
          end
        end
      end
      kpn_pkg::S_T_DIV1: begin
        state_d = kpn_pkg::S_T_DIV1_WAIT;
      end
      kpn_pkg::S_T_DIV1_WAIT: begin
        if (div_done) begin
          if (div_rem != '0) begin
            d_d     = d_q + DivW'(2);
            state_d = kpn_pkg::S_T_POW;
          end else begin
            state_d = kpn_pkg::S_T_DIV2;
          end
        end
      end
      kpn_pkg::S_T_DIV2: begin
        state_d = kpn_pkg::S_T_DIV2_WAIT;
      end
      kpn_pkg::S_T_DIV2_WAIT: begin
        if (div_done) begin
          if (div_rem != '0) begin
            flag_d  = 1'b0;
            state_d = kpn_pkg::S_DONE;
          end else begin
            n_d     = div_quot;
            state_d = kpn_pkg::S_T_DIV3;
          end
        end
      end
      kpn_pkg::S_T_DIV3: begin
        state_d = kpn_pkg::S_T_DIV3_WAIT;
      end
      kpn_pkg::S_T_DIV3_WAIT: begin
        if (div_done) begin
          if (div_rem == '0) begin
            n_d     = div_quot;
            state_d = kpn_pkg::S_T_DIV3;
          end else if (n_q == W'(1)) begin
            flag_d  = 1'b1;
            state_d = kpn_pkg::S_DONE;
          end else begin
            pp_ctx_d = 1'b1;
            e_d      = 7'(k_q);
            state_d  = kpn_pkg::S_PP_E;
          end
        end
      end
      kpn_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = kpn_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kpn_pkg::S_IDLE;
      end
    endcase
  end

  // Unit starts, operand selection and handshake outputs.
  always_comb begin
    mul_start  = 1'b0;
    mul_a      = acc_q;
    mul_b      = base_q;
    div_start  = 1'b0;
    div_den    = W'(d_q);
    in_stall_o = (state_q != kpn_pkg::S_IDLE);
    load_out   = 1'b0;
    unique case (state_q)
      kpn_pkg::S_POW_LOOP: begin
        mul_start = (cnt_q != '0);
      end
      kpn_pkg::S_T_SQ: begin
        mul_start = 1'b1;
        mul_a     = pk_q;
        mul_b     = pk_q;
      end
      kpn_pkg::S_T_DIV1, kpn_pkg::S_T_DIV3: begin
        div_start = 1'b1;
      end
      kpn_pkg::S_T_DIV2: begin
        div_start = 1'b1;
        div_den   = pk_q;
      end
      kpn_pkg::S_DONE: begin
        load_out = !out_valid_q || !out_stall_i;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // Output register: loads a finished result, empties when its beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_flag_d  = out_flag_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_flag_d  = flag_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kpn_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    k_q       <= k_d;
    e_q       <= e_d;
    b_q       <= b_d;
    root_q    <= root_d;
    eqf_q     <= eqf_d;
    base_q    <= base_d;
    acc_q     <= acc_d;
    cnt_q     <= cnt_d;
    fit_q     <= fit_d;
    pow_ctx_q <= pow_ctx_d;
    pp_ctx_q  <= pp_ctx_d;
    d_q       <= d_d;
    pk_q      <= pk_d;
    flag_q    <= flag_d;
    out_flag_q <= out_flag_d;
  end

  assign out_valid_o        = out_valid_q;
  assign is_powerful_flag_o = out_flag_q;

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [63:0] word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  word_t      value_i;
  logic [5:0] exponent_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       is_powerful_flag_o;

  // Flags still owed by the block, oldest first.
  bit         flag_queue[$];
  int         mismatch_count;
  int         orphan_count;
  // Idle pattern: 0 sender busy-ish, 1 swapped, 2 no idling.
  int         idle_mode;
  int         hold_cycles;

  k_powerful_number_test dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .value_i            (value_i),
    .exponent_i         (exponent_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .is_powerful_flag_o (is_powerful_flag_o)
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // True when r^e does not exceed n; res gets r^e in that case.
  function automatic bit power_fits(word_t r, int e, word_t n, output word_t res);
    word_t acc;
    acc = 64'd1;
    res = 64'd0;
    for (int i = 0; i < e; i++) begin
      if (r != 0 && acc > n / r) return 1'b0;
      acc = acc * r;
    end
    res = acc;
    return 1'b1;
  endfunction

  // True when n is m^e for some m >= 2 and some e >= k.
  function automatic bit is_high_power(word_t n, int k);
    word_t lo, hi, mid, t;
    int    sh;
    for (int e = k; e < 64; e++) begin
      sh = 64 / e + 1;
      lo = 64'd1;
      hi = 64'd1 << ((sh > 63) ? 63 : sh);
      while (lo < hi) begin
        mid = lo + (hi - lo + 64'd1) / 2;
        if (power_fits(mid, e, n, t)) lo = mid;
        else hi = mid - 64'd1;
      end
      if (lo < 2) return 1'b0;
      if (power_fits(lo, e, n, t) && t == n) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Expected flag for value n and exponent k.
  function automatic bit k_powerful(word_t n, int k);
    word_t d, pk;
    if (n <= 1) return n == 1;
    if (k <= 1) return 1'b1;
    if (n[0] == 1'b0) begin
      if ((n & ((64'd1 << k) - 64'd1)) != 0) return 1'b0;
      while (n[0] == 1'b0) n = n >> 1;
      if (n == 1) return 1'b1;
    end
    if (k > kpn_pkg::MAX_ODD_EXPONENT) return 1'b0;
    if (is_high_power(n, k)) return 1'b1;
    d = 64'd3;
    forever begin
      if (!power_fits(d, k, n, pk)) return 1'b0;
      if (pk > n / pk) return 1'b0;
      if (n % d == 0) begin
        if (n % pk != 0) return 1'b0;
        n = n / pk;
        while (n % d == 0) n = n / d;
        if (n == 1 || is_high_power(n, k)) return 1'b1;
      end
      d = d + 64'd2;
    end
  endfunction

  // Idle as the mode says, then offer one beat and wait for it to be taken.
  // The stall is sampled mid-cycle, where it is settled for the coming edge.
  task automatic send_value(word_t n, int k);
    logic stalled;
    if (idle_mode != 2) begin
      while ($urandom_range(99) < ((idle_mode == 0) ? 38 : 57)) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    value_i    <= n;
    exponent_i <= k[5:0];
    forever begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
      if (!stalled) break;
    end
    flag_queue.push_back(k_powerful(n, k));
  endtask

  // Lower valid and wait for every owed flag, plus a margin.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (flag_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Cheap random value: a product of small odd prime powers shifted by some twos.
  function automatic word_t smooth_value();
    word_t v, p;
    int    reps;
    v = 64'd1;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(4))
        0: p = 64'd3;
        1: p = 64'd5;
        2: p = 64'd7;
        3: p = 64'd11;
        default: p = 64'd13;
      endcase
      reps = $urandom_range(8);
      for (int j = 0; j < reps; j++) if (v <= 64'hFFFF_FFFF_FFFF_FFFF / p) v = v * p;
    end
    reps = $urandom_range(12);
    for (int j = 0; j < reps; j++) if (v[63] == 1'b0) v = v << 1;
    return v;
  endfunction

  // One random beat from a mix of shapes that all finish quickly.
  task automatic send_random();
    word_t v;
    case ($urandom_range(3))
      0: send_value({$urandom(), $urandom()} & 64'hF_FFFF, $urandom_range(63));
      1: send_value({$urandom(), $urandom()}, $urandom_range(6, 63));
      2: send_value(smooth_value(), $urandom_range(2, 6));
      default: begin
        // Square only where it fits, so the value stays smooth.
        v = smooth_value();
        if (v <= 64'hFFFF_FFFF) v = v * v;
        send_value(v, $urandom_range(2, 4));
      end
    endcase
  endtask

  task automatic test_trivial();
    send_value(64'd0, 0);
    send_value(64'd0, 63);
    send_value(64'd1, 0);
    send_value(64'd1, 63);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_value(64'hFFFF_FFFF_FFFF_FFFE, 1);
    drain();
  endtask

  task automatic test_even();
    send_value(64'd12, 3);
    send_value(64'h8000_0000_0000_0000, 63);
    send_value(64'h8000_0000_0000_0000, 62);
    send_value(64'h4000_0000_0000_0000, 63);
    send_value(64'd72, 2);
    send_value(64'd96, 5);
    drain();
  endtask

  task automatic test_odd_limits();
    // Three to the fortieth: exponent at the limit and just over it.
    send_value(64'd12157665459056928801, 40);
    send_value(64'd12157665459056928801, 41);
    send_value(64'd6, 41);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 2);
    send_value(64'd2147483647, 2);
    send_value(64'd225, 2);
    send_value(64'd675, 2);
    send_value(64'd3375, 3);
    send_value(64'hFFFF_FFFF_FFFF_FFFD, 63);
    send_value(64'hFFFF_FFFF_FFFF_FFFD, 20);
    drain();
  endtask

  task automatic test_random_phase(int mode, int count);
    idle_mode = mode;
    for (int i = 0; i < count; i++) send_random();
    drain();
  endtask

  // Receiver holds off while beats keep coming, then the sender waits for all flags.
  task automatic test_backpressure();
    idle_mode   = 2;
    hold_cycles = 400;
    for (int i = 0; i < 6; i++) send_value(64'd0 + i, 0);
    drain();
  endtask

  // Receiver: choose the stall for the coming cycle, then check the beat that it lets through.
  initial begin
    bit expected_flag;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (idle_mode == 2) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < ((idle_mode == 0) ? 57 : 38));
      end
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (flag_queue.size() == 0) begin
          orphan_count++;
          if (orphan_count + mismatch_count <= 10)
            $display("unexpected flag %0b", is_powerful_flag_o);
        end else begin
          expected_flag = flag_queue.pop_front();
          if (is_powerful_flag_o !== expected_flag) begin
            mismatch_count++;
            if (orphan_count + mismatch_count <= 10)
              $display("flag mismatch: expected %0b, got %0b", expected_flag,
                       is_powerful_flag_o);
          end
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    value_i        = '0;
    exponent_i     = '0;
    mismatch_count = 0;
    orphan_count   = 0;
    idle_mode      = 2;
    hold_cycles    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_trivial();
    test_even();
    test_odd_limits();
    test_backpressure();
    test_random_phase(0, 24);
    test_random_phase(1, 24);
    test_random_phase(2, 24);
    if (mismatch_count == 0 && orphan_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog for a block that never answers.
  initial begin
    #2000ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== k_powerful_number_test.f =====
hw/rtl/kpn_pkg.sv
hw/rtl/kpn_mul.sv
hw/rtl/kpn_div.sv
hw/rtl/k_powerful_number_test.sv
tb/testbench.sv
